[rtl/sidlt_pkg.sv]
// Package for the slot ID lookup table: field widths, command and status
// codes, and the transaction structs shared by the top level and its users.
// No dependencies.
`default_nettype none

package sidlt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int ID_W          = 32;
    localparam int OBJ_W         = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic [ID_W-1:0] INVALID_ID_RESET = '1;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        mode_t            mode;
        logic [ID_W-1:0]  lookup_id;
        logic [OBJ_W-1:0] object_ref;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [ID_W-1:0]        result_id;
        logic [OBJ_W-1:0]       result_ref;
        logic [COUNT_OUT_W-1:0] occupied_count;
    } result_t;

    // One table entry: the slot's ID and the object it holds (0 = empty)
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [OBJ_W-1:0] obj;
    } entry_t;

endpackage

`default_nettype wire

[rtl/slot_id_lookup_table.sv]
// Slot ID lookup table: top level with the slot memory, the scan sequencer
// and the counters. Depends on sidlt_pkg.
//
//   channel   | signals                   | handshake
//   ----------+---------------------------+----------------------------------
//   command   | start, busy, cmd          | taken on start && !busy
//   result    | done, result              | one-cycle strobe, no back-pressure
//   config    | cfg_we, cfg_wdata         | written on cfg_we, no wait
//
// A transaction that is rejected up front, a clear, or a find/remove on an
// empty table answers in the cycle after it is taken, without raising busy.
// Otherwise the sequencer scans the single-port slot memory one entry per
// cycle (registered read); an add that finds room and a remove that hits
// then pass through a write-back state before the result.
// Reset clears the counters and the sequencer; memory contents are not reset.
// Results cannot be stalled.
`default_nettype none

module slot_id_lookup_table #(
    parameter int SLOTS = sidlt_pkg::SLOTS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire sidlt_pkg::cmd_t           cmd,
    output logic                           done,
    output sidlt_pkg::result_t             result,
    input  wire logic                      cfg_we,
    input  wire logic [sidlt_pkg::ID_W-1:0] cfg_wdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    sidlt_pkg::cmd_t                 op_reg, op_next;
    logic [CW-1:0]                   rd_idx_reg, rd_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]                   wr_idx_reg, wr_idx_next;
    sidlt_pkg::entry_t               wr_entry_reg, wr_entry_next;
    logic                            dec_reg, dec_next;
    logic [CW-1:0]                   in_use_reg, in_use_next;
    logic [CW-1:0]                   occ_reg, occ_next;
    logic [sidlt_pkg::ID_W-1:0]      next_id_reg, next_id_next;
    logic [sidlt_pkg::ID_W-1:0]      invalid_id_reg;
    logic                            done_reg, done_next;
    sidlt_pkg::result_t              res_reg, res_next;
    sidlt_pkg::entry_t               rd_data_reg;

    sidlt_pkg::entry_t               mem [SLOTS];
    logic                            mem_rd_en;
    logic                            mem_we;
    logic [IW-1:0]                   mem_addr;

    logic                            hit;
    logic                            last;
    logic                            id_bad;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Entry under compare this cycle matches the pending command (for add: is an empty slot)
    always_comb
    begin
        case (op_reg.mode)
            sidlt_pkg::MODE_ADD: hit = (rd_data_reg.obj == '0);
            default:             hit = (rd_data_reg.id == op_reg.lookup_id);
        endcase
    end

    assign last   = ((CW'(cmp_idx_reg) + CW'(1)) == in_use_reg);
    assign id_bad = (cmd.lookup_id == invalid_id_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wr_entry_next  = wr_entry_reg;
        dec_next       = dec_reg;
        in_use_next    = in_use_reg;
        occ_next       = occ_reg;
        next_id_next   = next_id_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        mem_rd_en      = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = rd_idx_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd;
                    rd_idx_next = '0;
                    dec_next    = 1'b0;
                    res_next.status         = sidlt_pkg::ST_OK;
                    res_next.result_id      = '0;
                    res_next.result_ref     = '0;
                    res_next.occupied_count = sidlt_pkg::COUNT_OUT_W'(occ_reg);
                    if (cmd.mode == sidlt_pkg::MODE_CLEAR)
                    begin
                        in_use_next = '0;
                        occ_next    = '0;
                        res_next.occupied_count = '0;
                        done_next   = 1'b1;
                    end
                    else if ((cmd.mode != sidlt_pkg::MODE_ADD && id_bad) ||
                             (cmd.mode == sidlt_pkg::MODE_ADD && cmd.object_ref == '0))
                    begin
                        res_next.status = sidlt_pkg::ST_INVALID;
                        done_next       = 1'b1;
                    end
                    else if (in_use_reg == '0)
                    begin
                        if (cmd.mode == sidlt_pkg::MODE_ADD)
                        begin
                            // Append the first slot
                            wr_idx_next       = '0;
                            wr_entry_next.id  = next_id_reg;
                            wr_entry_next.obj = cmd.object_ref;
                            in_use_next       = CW'(1);
                            state_next        = S_WRITE;
                        end
                        else
                        begin
                            res_next.status = sidlt_pkg::ST_NOT_FOUND;
                            done_next       = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while comparing the previous one
                if (rd_idx_reg < in_use_reg)
                begin
                    mem_rd_en      = 1'b1;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[IW-1:0];
                end
                if (cmp_valid_reg)
                begin
                    if (hit)
                    begin
                        case (op_reg.mode)
                            sidlt_pkg::MODE_FIND:
                            begin
                                res_next.result_ref = rd_data_reg.obj;
                                done_next           = 1'b1;
                                state_next          = S_IDLE;
                            end
                            sidlt_pkg::MODE_REMOVE:
                            begin
                                wr_idx_next       = cmp_idx_reg;
                                wr_entry_next.id  = rd_data_reg.id;
                                wr_entry_next.obj = '0;
                                dec_next          = (rd_data_reg.obj != '0);
                                state_next        = S_WRITE;
                            end
                            default:
                            begin
                                // Reuse the empty slot
                                wr_idx_next       = cmp_idx_reg;
                                wr_entry_next.id  = next_id_reg;
                                wr_entry_next.obj = op_reg.object_ref;
                                state_next        = S_WRITE;
                            end
                        endcase
                    end
                    else if (last)
                    begin
                        if (op_reg.mode == sidlt_pkg::MODE_ADD)
                        begin
                            if (in_use_reg < CW'(SLOTS))
                            begin
                                wr_idx_next       = in_use_reg[IW-1:0];
                                wr_entry_next.id  = next_id_reg;
                                wr_entry_next.obj = op_reg.object_ref;
                                in_use_next       = in_use_reg + CW'(1);
                                state_next        = S_WRITE;
                            end
                            else
                            begin
                                res_next.status = sidlt_pkg::ST_FULL;
                                done_next       = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            res_next.status = sidlt_pkg::ST_NOT_FOUND;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                end
            end

            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_addr   = wr_idx_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg.mode == sidlt_pkg::MODE_ADD)
                begin
                    next_id_next       = next_id_reg + sidlt_pkg::ID_W'(1);
                    res_next.result_id = next_id_reg;
                    if (occ_reg < CW'(SLOTS))
                    begin
                        occ_next = occ_reg + CW'(1);
                    end
                end
                else if (dec_reg && occ_reg != '0)
                begin
                    occ_next = occ_reg - CW'(1);
                end
                res_next.occupied_count = sidlt_pkg::COUNT_OUT_W'(occ_next);
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_valid_reg  <= 1'b0;
            in_use_reg     <= '0;
            occ_reg        <= '0;
            next_id_reg    <= '0;
            invalid_id_reg <= sidlt_pkg::INVALID_ID_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            in_use_reg    <= in_use_next;
            occ_reg       <= occ_next;
            next_id_reg   <= next_id_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                invalid_id_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        wr_idx_reg   <= wr_idx_next;
        wr_entry_reg <= wr_entry_next;
        dec_reg      <= dec_next;
        res_reg      <= res_next;
    end

    // Single-port slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wr_entry_reg;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // A result always lands with the sequencer back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");

    // Occupied slots never exceed slots in use, which never exceed SLOTS
    assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= in_use_reg) && (in_use_reg <= CW'(SLOTS)))
        else $error("slot counters out of range");

    // Scan never reads past the slots in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= in_use_reg))
        else $error("scan index beyond slots in use");

    // Each write-back is followed by exactly one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (done && state_reg == S_IDLE))
        else $error("write-back did not complete the transaction");

endmodule

`default_nettype wire
